FILE: src/segx_pkg.sv
// Shared widths and the divider chain payload for the segment crossing block.
package segx_pkg;
  localparam int COORD_BITS = 18;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DET_W = PROD_W + 1;
  localparam int QUO_W = DIFF_W;
  localparam int REM_W = DET_W;
  localparam int NUM_W = DET_W + DIFF_W;
  localparam int MINDET_W = 41;
  localparam int CELLS = QUO_W;

  typedef struct packed {
    logic                         valid;
    logic                         hit;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic [DET_W-1:0]             den;
    logic [REM_W-1:0]             rem_x;
    logic [REM_W-1:0]             rem_y;
    logic [QUO_W-1:0]             quo_x;
    logic [QUO_W-1:0]             quo_y;
  } div_t;
endpackage

FILE: src/segx_front.sv
// Front pipeline: directions, cross products, parameter tests, numerators.
module segx_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   take,
  input  logic [segx_pkg::MINDET_W-1:0]          min_det,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_start_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_start_y,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_end_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_end_y,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_start_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_start_y,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_end_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_end_y,
  output segx_pkg::div_t                         o
);
  localparam int CW = segx_pkg::COORD_BITS;
  localparam int DW = segx_pkg::DIFF_W;
  localparam int PW = segx_pkg::PROD_W;
  localparam int TW = segx_pkg::DET_W;
  localparam int NW = segx_pkg::NUM_W;
  localparam int QW = segx_pkg::QUO_W;

  logic [3:0] v;
  logic signed [CW-1:0] ax1, ay1, ax2, ay2, ax3, ay3, ax4, ay4;
  logic signed [DW-1:0] rx, ry, qx, qy, wx, wy;
  logic signed [DW-1:0] rx2, ry2, rx3, ry3;
  logic signed [PW-1:0] p_rq, p_rq2, p_sa, p_sb, p_ta, p_tb;
  logic signed [TW-1:0] det, sn, tn;
  logic hit4;
  logic [TW-1:0] den4, tn4;
  logic [DW-1:0] mrx4, mry4;
  logic nx4, ny4;

  logic signed [TW-1:0] det_n, sn_n, tn_n, det_abs;
  logic ok;
  logic [NW-1:0] num_x, num_y;

  always_comb begin
    det_abs = det[TW-1] ? -det : det;
    det_n = det_abs;
    sn_n = det[TW-1] ? -sn : sn;
    tn_n = det[TW-1] ? -tn : tn;
    ok = (det != '0) && ({{(segx_pkg::MINDET_W-TW){1'b0}}, det_abs} >= min_det) &&
         !sn_n[TW-1] && (sn_n <= det_n) && !tn_n[TW-1] && (tn_n <= det_n);
    num_x = NW'(tn4) * NW'(mrx4);
    num_y = NW'(tn4) * NW'(mry4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      o.valid <= 1'b0;
    end else begin
      v <= {v[2:0], take};
      o.valid <= v[3];
    end
    ax1 <= first_start_x;
    ay1 <= first_start_y;
    rx <= DW'(first_end_x) - DW'(first_start_x);
    ry <= DW'(first_end_y) - DW'(first_start_y);
    qx <= DW'(second_end_x) - DW'(second_start_x);
    qy <= DW'(second_end_y) - DW'(second_start_y);
    wx <= DW'(first_start_x) - DW'(second_start_x);
    wy <= DW'(first_start_y) - DW'(second_start_y);

    ax2 <= ax1;
    ay2 <= ay1;
    rx2 <= rx;
    ry2 <= ry;
    p_rq <= rx * qy;
    p_rq2 <= ry * qx;
    p_sa <= rx * wy;
    p_sb <= ry * wx;
    p_ta <= qx * wy;
    p_tb <= qy * wx;

    ax3 <= ax2;
    ay3 <= ay2;
    rx3 <= rx2;
    ry3 <= ry2;
    det <= TW'(p_rq) - TW'(p_rq2);
    sn <= TW'(p_sa) - TW'(p_sb);
    tn <= TW'(p_ta) - TW'(p_tb);

    ax4 <= ax3;
    ay4 <= ay3;
    hit4 <= ok;
    den4 <= ok ? det_n : TW'(1);
    tn4 <= ok ? tn_n : '0;
    nx4 <= rx3[DW-1];
    ny4 <= ry3[DW-1];
    mrx4 <= rx3[DW-1] ? -rx3 : rx3;
    mry4 <= ry3[DW-1] ? -ry3 : ry3;

    o.ax <= ax4;
    o.ay <= ay4;
    o.hit <= hit4;
    o.neg_x <= nx4;
    o.neg_y <= ny4;
    o.den <= den4;
    o.rem_x <= num_x[NW-1:QW];
    o.quo_x <= num_x[QW-1:0];
    o.rem_y <= num_y[NW-1:QW];
    o.quo_y <= num_y[QW-1:0];
  end
endmodule

FILE: src/segx_div_cell.sv
// One restoring division step for both coordinates, registered.
module segx_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  segx_pkg::div_t d,
  output segx_pkg::div_t q
);
  localparam int RW = segx_pkg::REM_W;
  localparam int QW = segx_pkg::QUO_W;

  logic [RW:0] tx, ty, dd;
  logic gx, gy;

  always_comb begin
    dd = {1'b0, d.den};
    tx = {d.rem_x, d.quo_x[QW-1]};
    ty = {d.rem_y, d.quo_y[QW-1]};
    gx = tx >= dd;
    gy = ty >= dd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= d.valid;
    end
    q.hit <= d.hit;
    q.neg_x <= d.neg_x;
    q.neg_y <= d.neg_y;
    q.ax <= d.ax;
    q.ay <= d.ay;
    q.den <= d.den;
    q.rem_x <= RW'(gx ? tx - dd : tx);
    q.rem_y <= RW'(gy ? ty - dd : ty);
    q.quo_x <= {d.quo_x[QW-2:0], gx};
    q.quo_y <= {d.quo_y[QW-2:0], gy};
  end
endmodule

FILE: src/segment_intersection.sv
// Top level: segment crossing test with a chain of divider cells.
// Throughput: one item per cycle; busy stays low, one quotient bit per cell.
// Reset clears the valid chain and sets min_det to 1.
// The receiver cannot stall: each result shows for one cycle with done.
module segment_intersection (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_start_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_start_y,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_end_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] first_end_y,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_start_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_start_y,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_end_x,
  input  logic signed [segx_pkg::COORD_BITS-1:0] second_end_y,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [segx_pkg::MINDET_W-1:0]          cfg_data,
  output logic                                   done,
  output logic                                   hit,
  output logic signed [segx_pkg::COORD_BITS-1:0] cross_x,
  output logic signed [segx_pkg::COORD_BITS-1:0] cross_y
);
  localparam int CW = segx_pkg::COORD_BITS;
  localparam int QW = segx_pkg::QUO_W;
  localparam int N = segx_pkg::CELLS;

  logic [segx_pkg::MINDET_W-1:0] min_det;
  segx_pkg::div_t chain [N+1];
  segx_pkg::div_t last;
  logic signed [CW+1:0] ox, oy, sx, sy;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_det <= segx_pkg::MINDET_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      min_det <= cfg_data;
    end
  end

  segx_front u_front (
    .clk, .rst, .take(start && !busy), .min_det,
    .first_start_x, .first_start_y, .first_end_x, .first_end_y,
    .second_start_x, .second_start_y, .second_end_x, .second_end_y,
    .o(chain[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    segx_div_cell u_cell (.clk, .rst, .d(chain[i]), .q(chain[i+1]));
  end

  assign last = chain[N];

  always_comb begin
    sx = $signed({1'b0, last.quo_x[QW-1:0]});
    sy = $signed({1'b0, last.quo_y[QW-1:0]});
    ox = (CW+2)'(last.ax) + (last.neg_x ? -sx : sx);
    oy = (CW+2)'(last.ay) + (last.neg_y ? -sy : sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    hit <= last.hit;
    cross_x <= last.hit ? ox[CW-1:0] : '0;
    cross_y <= last.hit ? oy[CW-1:0] : '0;
  end
endmodule

FILE: dv/tb_segment_intersection.sv
// Testbench for segment_intersection: directed table, then random segment pairs.
module tb_segment_intersection;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 25;
  localparam int WATCHDOG = 2000;
  localparam int N_RANDOM = 400;

  typedef logic signed [segx_pkg::COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy, ex, ey;
  } seg_pair_t;

  typedef struct packed {
    logic   hit;
    coord_t x;
    coord_t y;
  } crossing_t;

  typedef struct {
    seg_pair_t p;
    logic      known;
    crossing_t res;
  } vector_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  coord_t first_start_x = '0, first_start_y = '0, first_end_x = '0, first_end_y = '0;
  coord_t second_start_x = '0, second_start_y = '0, second_end_x = '0, second_end_y = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [segx_pkg::MINDET_W-1:0] cfg_data = '0;
  logic done, hit;
  coord_t cross_x, cross_y;

  logic [segx_pkg::MINDET_W-1:0] min_det_model;
  crossing_t pending_crossings[$];
  int errors = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1'b1;

  always #4 clk = ~clk;

  segment_intersection DUT (.*);

  // signed division truncating toward zero on 64-bit magnitudes
  function automatic longint trunc_div(longint n, longint d);
    longint q;
    q = (n < 0 ? -n : n) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    longint rx, ry, qx, qy, wx, wy, det, sn, tn, adet;
    r = '0;
    rx = longint'(p.bx) - p.ax; ry = longint'(p.by) - p.ay;
    qx = longint'(p.ex) - p.cx; qy = longint'(p.ey) - p.cy;
    wx = longint'(p.ax) - p.cx; wy = longint'(p.ay) - p.cy;
    det = rx * qy - ry * qx;
    sn = rx * wy - ry * wx;
    tn = qx * wy - qy * wx;
    adet = det < 0 ? -det : det;
    if (det != 0 && adet >= longint'({23'b0, min_det_model})) begin
      if (det < 0) begin
        det = -det; sn = -sn; tn = -tn;
      end
      // tn*rx below 2^57, fits 64 bits
      if (sn >= 0 && sn <= det && tn >= 0 && tn <= det) begin
        r.hit = 1'b1;
        r.x = coord_t'(p.ax + trunc_div(tn * rx, det));
        r.y = coord_t'(p.ay + trunc_div(tn * ry, det));
      end
    end
    return r;
  endfunction

  task automatic idle_burst();
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_pair(seg_pair_t p, logic known, crossing_t res);
    crossing_t pred;
    idle_burst();
    pred = predict_crossing(p);
    if (known && pred !== res) begin
      $display("%0t table row disagrees: expected %p actual model %p", $time, res, pred);
      errors++;
    end
    start <= 1'b1;
    {first_start_x, first_start_y, first_end_x, first_end_y,
     second_start_x, second_start_y, second_end_x, second_end_y} <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_crossings.push_back(known ? res : pred);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_crossings.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_min_det(logic [segx_pkg::MINDET_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    min_det_model = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int span;
    span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(2, 16));
    p = {rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
         rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span)};
    case ($urandom_range(0, 5))
      0: begin
        // parallel copy of first direction
        p.ex = p.cx + (p.bx - p.ax);
        p.ey = p.cy + (p.by - p.ay);
      end
      1: begin
        // second starts on first endpoint
        p.cx = p.bx; p.cy = p.by;
      end
      default: ;
    endcase
    return p;
  endfunction

  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("tb_segment_intersection NOT OK");
        $finish;
      end
      if (done) begin
        if (pending_crossings.size() == 0) begin
          $display("%0t unexpected result: actual hit=%0b x=%0d y=%0d",
                   $time, hit, cross_x, cross_y);
          errors++;
        end else begin
          want = pending_crossings.pop_front();
          if (hit !== want.hit || cross_x !== want.x || cross_y !== want.y) begin
            $display("%0t mismatch: expected hit=%0b x=%0d y=%0d actual hit=%0b x=%0d y=%0d",
                     $time, want.hit, want.x, want.y, hit, cross_x, cross_y);
            errors++;
          end
        end
      end
    end
  end

  localparam coord_t CMAX = 18'sh1FFFF;
  localparam coord_t CMIN = 18'sh20000;

  vector_t directed[] = '{
    '{'{16, 0, 16, 32, 0, 16, 32, 16}, 1'b1, '{1'b1, 16, 16}},
    '{'{0, 0, 32, 0, 0, 16, 32, 16}, 1'b1, '{1'b0, 0, 0}},
    '{'{0, 0, 32, 0, 16, 0, 48, 0}, 1'b1, '{1'b0, 0, 0}},
    '{'{0, 0, 32, 0, 32, -16, 32, 16}, 1'b1, '{1'b1, 32, 0}},
    '{'{0, 0, 32, 0, 0, 0, 0, 16}, 1'b1, '{1'b1, 0, 0}},
    '{'{0, 0, 32, 0, 48, -16, 48, 16}, 1'b1, '{1'b0, 0, 0}},
    '{'{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN}, 1'b0, '0},
    '{'{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX}, 1'b0, '0},
    '{'{CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX}, 1'b1, '{1'b1, 0, 0}},
    '{'{CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN}, 1'b1, '{1'b0, 0, 0}},
    '{'{-1, -1, 1, 1, -1, 1, 1, -1}, 1'b1, '{1'b1, 0, 0}},
    '{'{0, 0, 3, 1, 0, 1, 3, 0}, 1'b0, '0},
    '{'{0, 0, -3, -1, 0, -1, -3, 0}, 1'b0, '0}
  };

  initial begin
    seg_pair_t p;
    min_det_model = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_pair(directed[i].p, directed[i].known, directed[i].res);
    write_min_det('0);
    send_pair('{0, 0, 32, 0, 16, 0, 48, 0}, 1'b1, '{1'b0, 0, 0});
    send_pair('{16, 0, 16, 32, 0, 16, 32, 16}, 1'b1, '{1'b1, 16, 16});
    write_min_det({segx_pkg::MINDET_W{1'b1}});
    send_pair('{CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX}, 1'b1, '{1'b0, 0, 0});
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k % 100 == 0)
        case (k / 100)
          0: write_min_det(1);
          1: write_min_det(segx_pkg::MINDET_W'($urandom_range(1, 1 << 20)));
          2: write_min_det(segx_pkg::MINDET_W'(64'd1 << 40));
          default: write_min_det(1);
        endcase
      if (k >= N_RANDOM - 60) allow_gaps = 1'b0;
      p = rand_pair();
      send_pair(p, 1'b0, '0);
    end
    drain();
    if (errors == 0) $display("tb_segment_intersection OK");
    else $display("tb_segment_intersection NOT OK");
    $finish;
  end
endmodule
